/* rtl/core/sate_pkg.sv */
// Shared types and codes for the sorted table engine.
`timescale 1ns / 1ps
package sate_pkg;
	localparam int MODE_W   = 2;
	localparam int VALUE_W  = 32;
	localparam int STATUS_W = 2;
	localparam int OUT_W    = 5;

	localparam logic [MODE_W-1:0] MODE_SEARCH = 2'd0;
	localparam logic [MODE_W-1:0] MODE_INSERT = 2'd1;
	localparam logic [MODE_W-1:0] MODE_DELETE = 2'd2;

	localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
	localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
	localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 2'd2;
	localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 2'd3;

	typedef struct packed {
		logic capture;
		logic commit;
	} sate_ctl_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [OUT_W-1:0]    position;
		logic [OUT_W-1:0]    match_count;
		logic [OUT_W-1:0]    fill_level;
	} sate_res_t;
endpackage

/* rtl/core/sate_req_if.sv */
// Request channel: operation mode and operand value.
`timescale 1ns / 1ps
interface sate_req_if import sate_pkg::*; ;
	logic                      valid;
	logic                      ready;
	logic [MODE_W-1:0]         mode;
	logic signed [VALUE_W-1:0] value;

	modport source(output valid, output mode, output value, input ready);
	modport sink(input valid, input mode, input value, output ready);
endinterface

/* rtl/core/sate_rsp_if.sv */
// Response channel: status, slot, match count and fill level.
`timescale 1ns / 1ps
interface sate_rsp_if import sate_pkg::*; ;
	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic [OUT_W-1:0]    position;
	logic [OUT_W-1:0]    match_count;
	logic [OUT_W-1:0]    fill_level;

	modport source(output valid, output status, output position, output match_count,
		output fill_level, input ready);
	modport sink(input valid, input status, input position, input match_count,
		input fill_level, output ready);
endinterface

/* rtl/core/sorted_array_table_engine_unit.sv */
// A request is captured when accepted; its result is registered at the commit, which
// waits for a free result register. The cell row compares all entries in the
// accept cycle and shifts them in the commit cycle; a new request is taken only
// after the commit of the last one. Reset: asynchronous, empties the table at once with no clearing
// pass; table cells are not reset and are read only below the fill count.
`timescale 1ns / 1ps
module sorted_array_table_engine_unit import sate_pkg::*; #(
	parameter int CAPACITY = 16
) (
	input logic       clk,
	input logic       arst_n,
	sate_req_if.sink  req,
	sate_rsp_if.source rsp
);
	sate_ctl_t ctl;
	sate_res_t res;

	sate_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.ctl       (ctl)
	);

	sate_datapath #(.CAPACITY(CAPACITY)) u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.mode   (req.mode),
		.value  (req.value),
		.res    (res)
	);

	assign rsp.status      = res.status;
	assign rsp.position    = res.position;
	assign rsp.match_count = res.match_count;
	assign rsp.fill_level  = res.fill_level;
endmodule

/* rtl/core/sate_ctrl.sv */
// Controller: sequences compare and commit, owns the response valid flag.
`timescale 1ns / 1ps
module sate_ctrl import sate_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_ready,
	output logic      rsp_valid,
	input  logic      rsp_ready,
	output sate_ctl_t ctl
);
	localparam logic S_IDLE = 1'b0;
	localparam logic S_WORK = 1'b1;

	logic state_q;
	logic rsp_valid_q;

	assign req_ready   = (state_q == S_IDLE);
	assign rsp_valid   = rsp_valid_q;
	assign ctl.capture = req_valid && (state_q == S_IDLE);
	// The result register must be empty or emptying before a commit overwrites it.
	assign ctl.commit  = (state_q == S_WORK) && (!rsp_valid_q || rsp_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (ctl.capture) state_q <= S_WORK;
				end
				S_WORK: begin
					if (ctl.commit) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
			if (ctl.commit) rsp_valid_q <= 1'b1;
			else if (rsp_ready) rsp_valid_q <= 1'b0;
		end
	end
endmodule

/* rtl/core/sate_datapath.sv */
// Datapath: row of table cells with per-cell compare and local shift.
`timescale 1ns / 1ps
module sate_datapath import sate_pkg::*; #(
	parameter int CAPACITY = 16
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  sate_ctl_t                 ctl,
	input  logic [MODE_W-1:0]         mode,
	input  logic signed [VALUE_W-1:0] value,
	output sate_res_t                 res
);
	localparam int CNT_W = $clog2(CAPACITY + 1);

	logic [MODE_W-1:0]         mode_q;
	logic signed [VALUE_W-1:0] value_q;
	logic [CAPACITY-1:0]       lt_s1, le_s1;
	logic [CAPACITY-1:0]       lt_d, le_d;
	logic [CNT_W-1:0]          used_q, used_d;
	logic signed [VALUE_W-1:0] entries_q [CAPACITY];
	logic signed [VALUE_W-1:0] ins_src [CAPACITY];
	logic signed [VALUE_W-1:0] del_src [CAPACITY];
	logic [CNT_W-1:0]          lt_cnt, le_cnt;
	logic                      match, full, empty, do_ins, do_del;
	sate_res_t                 res_d, res_q;

	// Held entries are sorted and packed at the bottom, so each flag vector is a
	// thermometer code; its length is the index of the first clear flag.
	function automatic logic [CNT_W-1:0] therm_count(input logic [CAPACITY-1:0] t);
		logic [CAPACITY:0] tx;
		logic [CNT_W-1:0]  c;
		tx = {1'b0, t};
		c  = '0;
		for (int k = 0; k < CAPACITY; k++) begin
			if (tx[k] && !tx[k+1]) c = c | CNT_W'(k + 1);
		end
		return c;
	endfunction

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic held;
		assign held    = (CNT_W'(i) < used_q);
		assign lt_d[i] = held && (entries_q[i] < value);
		assign le_d[i] = held && (entries_q[i] <= value);

		if (i == 0) begin : g_first
			assign ins_src[i] = value_q;
		end else begin : g_rest
			assign ins_src[i] = le_s1[i-1] ? value_q : entries_q[i-1];
		end
		if (i == CAPACITY - 1) begin : g_last
			assign del_src[i] = entries_q[i];
		end else begin : g_inner
			assign del_src[i] = entries_q[i+1];
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < CAPACITY; i++) begin
			if (do_ins && !le_s1[i]) entries_q[i] <= ins_src[i];
			else if (do_del && !lt_s1[i]) entries_q[i] <= del_src[i];
		end
	end

	assign lt_cnt = therm_count(lt_s1);
	assign le_cnt = therm_count(le_s1);
	assign match  = (lt_s1 != le_s1);
	assign full   = (used_q == CNT_W'(CAPACITY));
	assign empty  = (used_q == '0);

	always_comb begin
		res_d.status      = ST_OK;
		res_d.position    = '0;
		res_d.match_count = '0;
		res_d.fill_level  = OUT_W'(used_q);
		used_d            = used_q;
		do_ins            = 1'b0;
		do_del            = 1'b0;
		case (mode_q)
			MODE_SEARCH: begin
				if (match) begin
					res_d.position    = OUT_W'(lt_cnt);
					res_d.match_count = OUT_W'(le_cnt - lt_cnt);
				end else begin
					res_d.status = ST_NOT_FOUND;
				end
			end
			MODE_INSERT: begin
				if (full) begin
					res_d.status = ST_OVERFLOW;
				end else begin
					do_ins           = ctl.commit;
					used_d           = used_q + CNT_W'(1);
					res_d.position   = OUT_W'(le_cnt);
					res_d.fill_level = OUT_W'(used_d);
				end
			end
			MODE_DELETE: begin
				if (empty) begin
					res_d.status = ST_UNDERFLOW;
				end else if (!match) begin
					res_d.status = ST_NOT_FOUND;
				end else begin
					do_del           = ctl.commit;
					used_d           = used_q - CNT_W'(1);
					res_d.position   = OUT_W'(lt_cnt);
					res_d.fill_level = OUT_W'(used_d);
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (ctl.capture) begin
			mode_q  <= mode;
			value_q <= value;
			lt_s1   <= lt_d;
			le_s1   <= le_d;
		end
		if (ctl.commit) res_q <= res_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= '0;
		end else if (ctl.commit) begin
			used_q <= used_d;
		end
	end

	assign res = res_q;
endmodule

/* rtl/core/sate_checker.sv */
// Port-level checks for the sorted table engine, bound to the top level.
`timescale 1ns / 1ps
module sate_checker import sate_pkg::*; (
	input logic                clk,
	input logic                arst_n,
	input logic                req_valid,
	input logic                req_ready,
	input logic                rsp_valid,
	input logic                rsp_ready,
	input logic [STATUS_W-1:0] status,
	input logic [OUT_W-1:0]    position,
	input logic [OUT_W-1:0]    match_count,
	input logic [OUT_W-1:0]    fill_level
);
	// Only one request is in flight: after an accepted transaction the port closes.
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request accepted while another was in flight");

	// Failed operations never report a slot or a match count.
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (status == ST_OVERFLOW || status == ST_UNDERFLOW ||
		status == ST_NOT_FOUND) |-> position == '0 && match_count == '0)
		else $error("failed operation reported nonzero slot or count");

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("response dropped while stalled");

	a_rsp_stable: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> $stable(status) && $stable(position) &&
		$stable(match_count) && $stable(fill_level))
		else $error("response payload changed while stalled");
endmodule

bind sorted_array_table_engine_unit sate_checker u_sate_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.req_valid   (req.valid),
	.req_ready   (req.ready),
	.rsp_valid   (rsp.valid),
	.rsp_ready   (rsp.ready),
	.status      (rsp.status),
	.position    (rsp.position),
	.match_count (rsp.match_count),
	.fill_level  (rsp.fill_level)
);

/* bench/sorted_array_table_engine_unit_test.sv */
// Self-checking testbench for the sorted table engine: directed plan, random traffic, predictor.
`timescale 1ns / 1ps
module sorted_array_table_engine_unit_test;
	import sate_pkg::*;

	localparam int TABLE_DEPTH = 16;
	localparam int RANDOM_OPS = 1800;
	localparam int CYCLE_LIMIT = 200000;
	localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;
	localparam logic signed [VALUE_W-1:0] VALUE_MIN = 32'sh8000_0000;
	localparam logic signed [VALUE_W-1:0] VALUE_MAX = 32'sh7fff_ffff;

	typedef struct {
		logic [MODE_W-1:0]         mode;
		logic signed [VALUE_W-1:0] value;
		bit                        typed;
		sate_res_t                 want;
	} op_row_t;

	logic clk;
	logic arst_n;

	sate_req_if req_ch();
	sate_rsp_if rsp_ch();

	sorted_array_table_engine_unit #(
		.CAPACITY(TABLE_DEPTH)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.rsp(rsp_ch)
	);

	// Shadow copy of the table kept by the predictor.
	logic signed [VALUE_W-1:0] shadow_tbl [TABLE_DEPTH];
	int                        shadow_fill;

	sate_res_t pending_results [$];
	op_row_t   op_plan [$];
	int        fail_count;
	int        cycle_count;
	int        rsp_hold;
	bit        no_stall;
	sate_res_t check_want;

	always #5 clk = ~clk;

	function automatic sate_res_t table_apply(input logic [MODE_W-1:0] m,
		input logic signed [VALUE_W-1:0] v);
		sate_res_t r;
		int first;
		int cnt;
		int loc;
		r = '{status: ST_OK, position: '0, match_count: '0, fill_level: '0};
		first = -1;
		cnt = 0;
		loc = shadow_fill;
		case (m)
			MODE_SEARCH: begin
				for (int i = 0; i < shadow_fill; i++) begin
					if (shadow_tbl[i] == v) begin
						if (first < 0)
							first = i;
						cnt++;
					end
				end
				if (first >= 0) begin
					r.position = OUT_W'(first);
					r.match_count = OUT_W'(cnt);
				end else begin
					r.status = ST_NOT_FOUND;
				end
			end
			MODE_INSERT: begin
				if (shadow_fill >= TABLE_DEPTH) begin
					r.status = ST_OVERFLOW;
				end else begin
					// Equal entries stay ahead of the new one.
					for (int i = 0; i < shadow_fill; i++) begin
						if (v < shadow_tbl[i]) begin
							loc = i;
							break;
						end
					end
					for (int i = shadow_fill; i > loc; i--)
						shadow_tbl[i] = shadow_tbl[i-1];
					shadow_tbl[loc] = v;
					shadow_fill++;
					r.position = OUT_W'(loc);
				end
			end
			MODE_DELETE: begin
				if (shadow_fill == 0) begin
					r.status = ST_UNDERFLOW;
				end else begin
					for (int i = 0; i < shadow_fill; i++) begin
						if (shadow_tbl[i] == v) begin
							first = i;
							break;
						end
					end
					if (first < 0) begin
						r.status = ST_NOT_FOUND;
					end else begin
						for (int i = first; i + 1 < shadow_fill; i++)
							shadow_tbl[i] = shadow_tbl[i+1];
						shadow_fill--;
						r.position = OUT_W'(first);
					end
				end
			end
			default: ;
		endcase
		r.fill_level = OUT_W'(shadow_fill);
		return r;
	endfunction

	task automatic plan_row(input logic [MODE_W-1:0] m, input logic signed [VALUE_W-1:0] v,
		input bit typed, input logic [STATUS_W-1:0] st, input int pos, input int cnt,
		input int fill);
		op_row_t row;
		row.mode = m;
		row.value = v;
		row.typed = typed;
		row.want = '{status: st, position: OUT_W'(pos), match_count: OUT_W'(cnt),
			fill_level: OUT_W'(fill)};
		op_plan.push_back(row);
	endtask

	// Called at a falling edge; returns at the falling edge after the transaction.
	task automatic issue_op(input logic [MODE_W-1:0] m, input logic signed [VALUE_W-1:0] v,
		input bit typed, input sate_res_t typed_want);
		int gap;
		sate_res_t predicted;
		gap = no_stall ? 0 : $urandom_range(0, 5);
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.mode <= m;
		req_ch.value <= v;
		do @(posedge clk); while (!req_ch.ready);
		predicted = table_apply(m, v);
		pending_results.push_back(typed ? typed_want : predicted);
		@(negedge clk);
	endtask

	function automatic logic signed [VALUE_W-1:0] pick_value();
		logic signed [VALUE_W-1:0] v;
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4: v = $signed(VALUE_W'($urandom_range(0, 6))) - 32'sd3;
			5: begin
				case ($urandom_range(0, 2))
					0: v = VALUE_MIN;
					1: v = VALUE_MAX;
					default: v = '0;
				endcase
			end
			6, 7: begin
				if (shadow_fill > 0)
					v = shadow_tbl[$urandom_range(0, shadow_fill - 1)];
				else
					v = $signed($urandom);
			end
			default: v = $signed($urandom);
		endcase
		return v;
	endfunction

	function automatic logic [MODE_W-1:0] pick_mode(input bit fill_bias);
		int r;
		r = $urandom_range(0, 99);
		if (r < 3)
			return MODE_SPARE;
		r = $urandom_range(0, 99);
		if (fill_bias)
			return (r < 60) ? MODE_INSERT : (r < 80) ? MODE_DELETE : MODE_SEARCH;
		return (r < 20) ? MODE_INSERT : (r < 75) ? MODE_DELETE : MODE_SEARCH;
	endfunction

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("FAIL sorted_array_table_engine_unit");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (pending_results.size() == 0) begin
				$error("unexpected result: status %0d position %0d", rsp_ch.status,
					rsp_ch.position);
				fail_count++;
			end else begin
				check_want = pending_results.pop_front();
				if (rsp_ch.status !== check_want.status) begin
					$error("status: expected %0d, actual %0d", check_want.status, rsp_ch.status);
					fail_count++;
				end
				if (rsp_ch.position !== check_want.position) begin
					$error("position: expected %0d, actual %0d", check_want.position,
						rsp_ch.position);
					fail_count++;
				end
				if (rsp_ch.match_count !== check_want.match_count) begin
					$error("match_count: expected %0d, actual %0d", check_want.match_count,
						rsp_ch.match_count);
					fail_count++;
				end
				if (rsp_ch.fill_level !== check_want.fill_level) begin
					$error("fill_level: expected %0d, actual %0d", check_want.fill_level,
						rsp_ch.fill_level);
					fail_count++;
				end
			end
			rsp_hold = no_stall ? 0 : $urandom_range(0, 5);
		end
	end

	always @(negedge clk) begin
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
		end else if (rsp_hold > 0) begin
			rsp_ch.ready <= 1'b0;
			rsp_hold = rsp_hold - 1;
		end else begin
			rsp_ch.ready <= 1'b1;
		end
	end

	initial begin
		sate_res_t none;
		bit fill_bias;
		clk = 1'b0;
		arst_n = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.mode = MODE_SEARCH;
		req_ch.value = '0;
		rsp_ch.ready = 1'b0;
		fail_count = 0;
		cycle_count = 0;
		rsp_hold = 0;
		no_stall = 1'b0;
		shadow_fill = 0;
		for (int i = 0; i < TABLE_DEPTH; i++)
			shadow_tbl[i] = '0;
		none = '{status: ST_OK, position: '0, match_count: '0, fill_level: '0};
		fill_bias = 1'b1;

		// Empty table, extremes at both ends, duplicates, misses, the spare mode, overflow and deletes.
		plan_row(MODE_SEARCH, 32'sd0, 1'b1, ST_NOT_FOUND, 0, 0, 0);
		plan_row(MODE_DELETE, 32'sd5, 1'b1, ST_UNDERFLOW, 0, 0, 0);
		plan_row(MODE_INSERT, VALUE_MIN, 1'b1, ST_OK, 0, 0, 1);
		plan_row(MODE_INSERT, VALUE_MAX, 1'b1, ST_OK, 1, 0, 2);
		plan_row(MODE_INSERT, 32'sd0, 1'b0, ST_OK, 0, 0, 0);
		plan_row(MODE_INSERT, 32'sd0, 1'b0, ST_OK, 0, 0, 0);
		plan_row(MODE_SEARCH, 32'sd0, 1'b0, ST_OK, 0, 0, 0);
		plan_row(MODE_SEARCH, 32'sd7, 1'b0, ST_OK, 0, 0, 0);
		plan_row(MODE_SPARE, 32'shaaaa_5555, 1'b1, ST_OK, 0, 0, 4);
		plan_row(MODE_DELETE, 32'sd12345, 1'b1, ST_NOT_FOUND, 0, 0, 4);
		plan_row(MODE_SEARCH, VALUE_MIN, 1'b1, ST_OK, 0, 1, 4);
		for (int i = 0; i < TABLE_DEPTH - 4; i++)
			plan_row(MODE_INSERT, 32'sd42, 1'b0, ST_OK, 0, 0, 0);
		plan_row(MODE_INSERT, -32'sd1, 1'b1, ST_OVERFLOW, 0, 0, TABLE_DEPTH);
		plan_row(MODE_SEARCH, 32'sd42, 1'b0, ST_OK, 0, 0, 0);
		plan_row(MODE_DELETE, VALUE_MAX, 1'b1, ST_OK, TABLE_DEPTH - 1, 0, TABLE_DEPTH - 1);
		plan_row(MODE_DELETE, 32'sd0, 1'b0, ST_OK, 0, 0, 0);

		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (op_plan[i])
			issue_op(op_plan[i].mode, op_plan[i].value, op_plan[i].typed, op_plan[i].want);

		for (int n = 0; n < RANDOM_OPS; n++) begin
			if (n % 120 == 0)
				fill_bias = ~fill_bias;
			if (n % 100 == 0)
				no_stall = ($urandom_range(0, 3) == 0);
			if (n == RANDOM_OPS / 2) begin
				// Hold the request side until the engine has drained completely.
				req_ch.valid <= 1'b0;
				@(negedge clk);
				while (pending_results.size() != 0)
					@(negedge clk);
			end
			issue_op(pick_mode(fill_bias), pick_value(), 1'b0, none);
		end
		req_ch.valid <= 1'b0;

		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (fail_count == 0)
			$display("PASS sorted_array_table_engine_unit");
		else
			$display("FAIL sorted_array_table_engine_unit");
		$finish;
	end
endmodule
